/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* rtl/bss_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte set statistics sorter package
// Field widths, default depth, and the command and status bundles that join
// the controller to the datapath.
// ---------------------------------------------------------------------------
package bss_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int DATA_W          = 8;
  localparam int POS_W           = 6;
  localparam int COUNT_W         = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sort_init;
    logic pivot_rd;
    logic pivot_ld;
    logic sweep;
    logic place;
    logic med_hi;
    logic med_lo;
    logic med_calc;
    logic div_start;
    logic div_step;
    logic emit_ld;
    logic emit_next;
    logic clear_set;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic sort_last;
    logic div_done;
    logic emit_last;
  } status_t;

endpackage

/* rtl/bss_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bss_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte set statistics sorter controller
// Sequences collection, rank sort, median, serial mean division and the
// emission of the sorted run.
// ---------------------------------------------------------------------------
module bss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             last_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output bss_pkg::cmd_t    cmd,
  input  bss_pkg::status_t status
);
  import bss_pkg::*;

  localparam logic [3:0] S_COLLECT   = 4'd0;
  localparam logic [3:0] S_PIV_RD    = 4'd1;
  localparam logic [3:0] S_PIV_LD    = 4'd2;
  localparam logic [3:0] S_SWEEP     = 4'd3;
  localparam logic [3:0] S_PLACE     = 4'd4;
  localparam logic [3:0] S_MED_HI    = 4'd5;
  localparam logic [3:0] S_MED_LO    = 4'd6;
  localparam logic [3:0] S_MED_CALC  = 4'd7;
  localparam logic [3:0] S_DIV       = 4'd8;
  localparam logic [3:0] S_EMIT_RD   = 4'd9;
  localparam logic [3:0] S_EMIT_LD   = 4'd10;
  localparam logic [3:0] S_EMIT_WAIT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready  = (state == S_COLLECT);
  assign out_valid = (state == S_EMIT_WAIT);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_COLLECT: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_sample) begin
            cmd.sort_init = 1'b1;
            state_next    = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        cmd.pivot_rd = 1'b1;
        state_next   = S_PIV_LD;
      end
      S_PIV_LD: begin
        cmd.pivot_ld = 1'b1;
        state_next   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = status.sort_last ? S_MED_HI : S_PIV_RD;
      end
      S_MED_HI: begin
        cmd.med_hi = 1'b1;
        state_next = S_MED_LO;
      end
      S_MED_LO: begin
        cmd.med_lo = 1'b1;
        state_next = S_MED_CALC;
      end
      S_MED_CALC: begin
        cmd.med_calc  = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          if (status.emit_last) begin
            cmd.clear_set = 1'b1;
            state_next    = S_COLLECT;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

endmodule

/* rtl/bss_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte set statistics sorter datapath
// Sample store, running statistics, rank sort into a second store, median
// pick, restoring divider for the mean, and the output word registers.
// ---------------------------------------------------------------------------
module bss_datapath #(
  parameter int MAX_SAMPLES = bss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bss_pkg::cmd_t               cmd,
  output bss_pkg::status_t            status,
  input  logic [bss_pkg::DATA_W-1:0]  sample,
  output logic [bss_pkg::DATA_W-1:0]  sorted_value,
  output logic [bss_pkg::POS_W-1:0]   position,
  output logic [bss_pkg::DATA_W-1:0]  median_value,
  output logic [bss_pkg::DATA_W-1:0]  mean_value,
  output logic [bss_pkg::DATA_W-1:0]  minimum_value,
  output logic [bss_pkg::DATA_W-1:0]  maximum_value,
  output logic [bss_pkg::COUNT_W-1:0] sample_count,
  output logic                        overflowed,
  output logic                        last_result
);
  import bss_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = $clog2(MAX_SAMPLES * 255 + 1);
  localparam int DIVC_W = $clog2(SUM_W);

  // Set statistics.
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] minv;
  logic [DATA_W-1:0] maxv;
  logic              ovf;

  // Sort indexes.
  logic [ADDR_W-1:0] i;
  logic [ADDR_W-1:0] cmp_idx;
  logic [ADDR_W-1:0] rank;
  logic [ADDR_W-1:0] k;
  logic [DATA_W-1:0] pivot;

  // Median and divider.
  logic [DATA_W-1:0] mid_hi;
  logic [DATA_W-1:0] median;
  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [DIVC_W-1:0] div_cnt;

  // Memory ports.
  logic              we_a;
  logic [ADDR_W-1:0] raddr_a;
  logic [DATA_W-1:0] rdata_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [DATA_W-1:0] rdata_b;

  logic              has_room;
  logic              take_rank;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  half_m1;
  logic [DATA_W:0]   pair_sum;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              rem_ge;

  assign has_room = (count < CNT_W'(MAX_SAMPLES));
  assign we_a     = cmd.load && has_room;
  assign half     = count >> 1;
  assign half_m1  = half - CNT_W'(1);
  assign pair_sum = {1'b0, rdata_b} + {1'b0, mid_hi};

  // A sample ranks below the pivot if larger, or equal and earlier.
  assign take_rank = (rdata_a > pivot) || ((rdata_a == pivot) && (cmp_idx < i));

  // One restoring division step.
  assign rem_sh   = {rem, quot[SUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, count});
  assign rem_diff = rem_sh - {1'b0, count};

  // Status to the controller.
  assign status.sweep_done = ((CNT_W'(cmp_idx) + CNT_W'(1)) == count);
  assign status.sort_last  = ((CNT_W'(i) + CNT_W'(1)) == count);
  assign status.emit_last  = ((CNT_W'(k) + CNT_W'(1)) == count);
  assign status.div_done   = (div_cnt == DIVC_W'(SUM_W - 1));

  // Sample store read address.
  always_comb begin
    if (cmd.pivot_ld) begin
      raddr_a = '0;
    end else if (cmd.sweep) begin
      raddr_a = cmp_idx + ADDR_W'(1);
    end else begin
      raddr_a = i;
    end
  end

  // Sorted store read address.
  always_comb begin
    if (cmd.med_hi) begin
      raddr_b = half[ADDR_W-1:0];
    end else if (cmd.med_lo) begin
      raddr_b = half_m1[ADDR_W-1:0];
    end else begin
      raddr_b = k;
    end
  end

  bss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (count[ADDR_W-1:0]),
    .wdata (sample),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  bss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_sorted_ram (
    .clk   (clk),
    .we    (cmd.place),
    .waddr (rank),
    .wdata (pivot),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Running statistics of the open set.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      count <= '0;
      sum   <= '0;
      minv  <= '1;
      maxv  <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (has_room) begin
        count <= count + CNT_W'(1);
        sum   <= sum + SUM_W'(sample);
        if (sample < minv) begin
          minv <= sample;
        end
        if (sample > maxv) begin
          maxv <= sample;
        end
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Rank sort counters: each pivot is compared against the whole set.
  always_ff @(posedge clk) begin
    if (rst) begin
      i       <= '0;
      cmp_idx <= '0;
      rank    <= '0;
    end else begin
      if (cmd.sort_init) begin
        i <= '0;
      end else if (cmd.place) begin
        i <= i + ADDR_W'(1);
      end
      if (cmd.pivot_rd) begin
        rank <= '0;
      end else if (cmd.sweep && take_rank) begin
        rank <= rank + ADDR_W'(1);
      end
      if (cmd.pivot_ld) begin
        cmp_idx <= '0;
      end else if (cmd.sweep) begin
        cmp_idx <= cmp_idx + ADDR_W'(1);
      end
    end
  end

  // Pivot and median registers.
  always_ff @(posedge clk) begin
    if (cmd.pivot_ld) begin
      pivot <= rdata_a;
    end
    if (cmd.med_lo) begin
      mid_hi <= rdata_b;
    end
    if (cmd.med_calc) begin
      median <= count[0] ? mid_hi : pair_sum[DATA_W:1];
    end
  end

  // Serial divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIVC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot <= sum;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[SUM_W-2:0], rem_ge};
      rem  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // Emission index.
  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) begin
      k <= '0;
    end else if (cmd.emit_next) begin
      k <= k + ADDR_W'(1);
    end
  end

  // Output word registers.
  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      sorted_value <= rdata_b;
      position     <= POS_W'(k);
      last_result  <= status.emit_last;
    end
  end

  assign median_value  = median;
  assign mean_value    = quot[DATA_W-1:0];
  assign minimum_value = minv;
  assign maximum_value = maxv;
  assign sample_count  = COUNT_W'(count);
  assign overflowed    = ovf;

endmodule

/* rtl/byte_set_statistics_sorter_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte set statistics sorter
// Collects byte samples into a set and, on the closing word, returns the set
// in descending order with median, mean, minimum and maximum on every word.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  sample, last_sample
//   output   out        out_valid/out_ready  sorted_value ... last_result
//
// While collecting, one input word is taken each cycle.
// After the closing word, the rank sort copies each kept sample to its rank
// in the sorted RAM, the median is read and formed, and the serial mean
// divider goes through the sum bit by bit (14 sum bits at the default depth).
// Each output word steps through emit read, load and a wait for out_ready; no
// input is taken until the last word of the run has been accepted.
// Reset empties the set; the stores need no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_set_statistics_sorter_top #(
  parameter int MAX_SAMPLES = bss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bss_pkg::DATA_W-1:0]  sample,
  input  logic                        last_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bss_pkg::DATA_W-1:0]  sorted_value,
  output logic [bss_pkg::POS_W-1:0]   position,
  output logic [bss_pkg::DATA_W-1:0]  median_value,
  output logic [bss_pkg::DATA_W-1:0]  mean_value,
  output logic [bss_pkg::DATA_W-1:0]  minimum_value,
  output logic [bss_pkg::DATA_W-1:0]  maximum_value,
  output logic [bss_pkg::COUNT_W-1:0] sample_count,
  output logic                        overflowed,
  output logic                        last_result
);
  import bss_pkg::*;

  cmd_t    cmd;
  status_t status;

  bss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status)
  );

  bss_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample        (sample),
    .sorted_value  (sorted_value),
    .position      (position),
    .median_value  (median_value),
    .mean_value    (mean_value),
    .minimum_value (minimum_value),
    .maximum_value (maximum_value),
    .sample_count  (sample_count),
    .overflowed    (overflowed),
    .last_result   (last_result)
  );

  // The block never collects and emits at the same time.
  `ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  // The last word of a run hands control back to collection.
  `ASSERT_NEXT(a_run_closes, clk, rst, out_valid && out_ready && last_result, in_ready)
  // Every emitted rank lies inside the set.
  `ASSERT_IMP(a_rank_range, clk, rst, out_valid, {1'b0, position} < sample_count)
  // Every emitted value lies between the set extremes.
  `ASSERT_IMP(a_value_range, clk, rst, out_valid,
              (minimum_value <= sorted_value) && (sorted_value <= maximum_value))

endmodule
